// ===== hw/rtl/tacdf_pkg.sv =====
// Package for the triangle area CDF builder: codes, command/status structs,
// and the multiply sequence table. No dependencies.
`default_nettype none
package tacdf_pkg;

	localparam int MAX_TRIANGLES_DEF = 1024;
	localparam int COORD_BITS_DEF    = 20;
	localparam int CDF_W             = 17;
	localparam int SUM_W             = 52;
	localparam int STATUS_W          = 2;
	localparam int ITER_W            = 6;
	localparam int STEP_W            = 4;
	localparam int DIV_ITERS         = 17;

	localparam logic [CDF_W-1:0]    CDF_ONE   = 17'h10000;
	localparam logic [SUM_W-1:0]    SUM_MAX   = {SUM_W{1'b1}};
	localparam logic [STEP_W-1:0]   MUL_LAST  = 4'd15;

	localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

	typedef enum logic [1:0] {
		ACT_CLEAR = 2'd0,
		ACT_ADD   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_NOP   = 2'd3
	} action_t;

	typedef enum logic [3:0] {
		S_IDLE, S_DECODE, S_MUL, S_SQRT, S_APPEND, S_RDMEM, S_DIV, S_ROUND, S_DONE
	} state_t;

	typedef enum logic [3:0] {
		OP_UX, OP_UY, OP_UZ, OP_VX, OP_VY, OP_VZ,
		OP_H0, OP_L0, OP_H1, OP_L1, OP_H2, OP_L2
	} opnd_t;

	typedef enum logic [2:0] {
		ACC_NONE, ACC_LOAD, ACC_SUB, ACC_SQHI, ACC_SQMID, ACC_SQLO
	} acc_t;

	typedef enum logic [1:0] {
		RES_ZERO, RES_ONE, RES_DIV
	} res_t;

	typedef struct packed {
		opnd_t      a;
		opnd_t      b;
		acc_t       acc;
		logic [1:0] tgt;
	} mstep_t;

	typedef struct packed {
		logic                capture;
		logic                clear;
		logic                mul_en;
		mstep_t              mstep;
		logic                sqrt_en;
		logic                append;
		logic                rd_en;
		logic                div_en;
		logic                div_first;
		logic                round_en;
		logic                out_load;
		res_t                res_kind;
		logic [STATUS_W-1:0] status;
	} tacdf_cmd_t;

	typedef struct packed {
		action_t action;
		logic    full;
		logic    idx_out;
		logic    idx_last;
		logic    total_zero;
	} tacdf_sts_t;

	// Multiply schedule: each step issues one product, and every step but the first
	// folds in the product issued by the step before.
	function automatic mstep_t step_cmd(input logic [STEP_W-1:0] step);
		mstep_t m;
		m = '{a: OP_UX, b: OP_UX, acc: ACC_NONE, tgt: 2'd0};
		case (step)
			4'd0:  m = '{a: OP_UY, b: OP_VZ, acc: ACC_NONE,  tgt: 2'd0};
			4'd1:  m = '{a: OP_UZ, b: OP_VY, acc: ACC_LOAD,  tgt: 2'd0};
			4'd2:  m = '{a: OP_UZ, b: OP_VX, acc: ACC_SUB,   tgt: 2'd0};
			4'd3:  m = '{a: OP_UX, b: OP_VZ, acc: ACC_LOAD,  tgt: 2'd1};
			4'd4:  m = '{a: OP_UX, b: OP_VY, acc: ACC_SUB,   tgt: 2'd1};
			4'd5:  m = '{a: OP_UY, b: OP_VX, acc: ACC_LOAD,  tgt: 2'd2};
			4'd6:  m = '{a: OP_H0, b: OP_H0, acc: ACC_SUB,   tgt: 2'd2};
			4'd7:  m = '{a: OP_H0, b: OP_L0, acc: ACC_SQHI,  tgt: 2'd0};
			4'd8:  m = '{a: OP_L0, b: OP_L0, acc: ACC_SQMID, tgt: 2'd0};
			4'd9:  m = '{a: OP_H1, b: OP_H1, acc: ACC_SQLO,  tgt: 2'd0};
			4'd10: m = '{a: OP_H1, b: OP_L1, acc: ACC_SQHI,  tgt: 2'd0};
			4'd11: m = '{a: OP_L1, b: OP_L1, acc: ACC_SQMID, tgt: 2'd0};
			4'd12: m = '{a: OP_H2, b: OP_H2, acc: ACC_SQLO,  tgt: 2'd0};
			4'd13: m = '{a: OP_H2, b: OP_L2, acc: ACC_SQHI,  tgt: 2'd0};
			4'd14: m = '{a: OP_L2, b: OP_L2, acc: ACC_SQMID, tgt: 2'd0};
			4'd15: m = '{a: OP_UX, b: OP_UX, acc: ACC_SQLO,  tgt: 2'd0};
			default: m = '{a: OP_UX, b: OP_UX, acc: ACC_NONE, tgt: 2'd0};
		endcase
		return m;
	endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/triangle_area_cdf_builder.sv =====
// Add: 16 multiply steps on one shared multiplier, then one root bit per cycle, then the
// append. Read: memory fetch, divide, round. Clear, no-op and rejects go straight out.
// Throughput: one item at a time; the next is taken once the last one has reached
// the output register, which holds a result while downstream stalls.
// Reset: arst_n clears count, total and handshake state at once; the prefix memory
// has no reset and is only read below the count.
`default_nettype none
module triangle_area_cdf_builder
	import tacdf_pkg::*;
#(
	parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF,
	parameter int INDEX_W       = $clog2(MAX_TRIANGLES),
	parameter int COUNT_W       = $clog2(MAX_TRIANGLES + 1),
	parameter int IN_W          = ((9 * COORD_BITS + INDEX_W + 7) / 8) * 8,
	parameter int OUT_W         = ((CDF_W + COUNT_W + 7) / 8) * 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// corner_a_x, corner_a_y, corner_a_z, corner_b_x .. corner_c_z, entry_index
	input  wire logic [IN_W-1:0]     s_tdata,
	// action
	input  wire logic [1:0]          s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// cdf_value, triangle_count
	output logic [OUT_W-1:0]         m_tdata,
	// status
	output logic [STATUS_W-1:0]      m_tuser
);
	tacdf_cmd_t cmd;
	tacdf_sts_t sts;

	// Sequencer: decode, multiply schedule, root and divide iteration counts
	tacdf_ctrl #(
		.COORD_BITS (COORD_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Arithmetic, prefix table and the output register
	tacdf_datapath #(
		.MAX_TRIANGLES (MAX_TRIANGLES),
		.COORD_BITS    (COORD_BITS),
		.INDEX_W       (INDEX_W),
		.COUNT_W       (COUNT_W),
		.IN_W          (IN_W),
		.OUT_W         (OUT_W)
	) u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule
`default_nettype wire

// ===== hw/rtl/tacdf_ctrl.sv =====
// Controller state machine of the triangle area CDF builder.
// Depends on tacdf_pkg; drives tacdf_datapath through tacdf_cmd_t.
`default_nettype none
module tacdf_ctrl
	import tacdf_pkg::*;
#(
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  wire logic       m_tready,
	input  wire tacdf_sts_t sts,
	output tacdf_cmd_t      cmd
);
	localparam int SQRT_ITERS = 2 * (COORD_BITS + 1);

	state_t              state_q, state_d;
	logic [STEP_W-1:0]   step_q, step_d;
	logic [ITER_W-1:0]   iter_q, iter_d;
	logic [STATUS_W-1:0] st_q, st_d;
	res_t                res_q, res_d;
	logic                out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			iter_q      <= '0;
			st_q        <= STATUS_OK;
			res_q       <= RES_ZERO;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
			iter_q  <= iter_d;
			st_q    <= st_d;
			res_q   <= res_d;
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign s_tready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		step_d  = step_q;
		iter_d  = iter_q;
		st_d    = st_q;
		res_d   = res_q;
		cmd     = '0;
		cmd.mstep = '{a: OP_UX, b: OP_UX, acc: ACC_NONE, tgt: 2'd0};
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = S_DECODE;
				end
			end
			S_DECODE: begin
				st_d    = STATUS_OK;
				res_d   = RES_ZERO;
				state_d = S_DONE;
				case (sts.action)
					ACT_CLEAR: cmd.clear = 1'b1;
					ACT_ADD: begin
						if (sts.full) begin
							st_d = STATUS_FULL;
						end else begin
							step_d  = '0;
							state_d = S_MUL;
						end
					end
					ACT_READ: begin
						if (sts.idx_out) begin
							st_d = STATUS_RANGE;
						end else if (sts.idx_last) begin
							res_d = RES_ONE;
						end else if (!sts.total_zero) begin
							res_d   = RES_DIV;
							state_d = S_RDMEM;
						end
					end
					default: ;
				endcase
			end
			S_MUL: begin
				cmd.mul_en = 1'b1;
				cmd.mstep  = step_cmd(step_q);
				step_d     = step_q + STEP_W'(1);
				if (step_q == MUL_LAST) begin
					iter_d  = '0;
					state_d = S_SQRT;
				end
			end
			S_SQRT: begin
				cmd.sqrt_en = 1'b1;
				iter_d      = iter_q + ITER_W'(1);
				if (iter_q == ITER_W'(SQRT_ITERS - 1))
					state_d = S_APPEND;
			end
			S_APPEND: begin
				cmd.append = 1'b1;
				state_d    = S_DONE;
			end
			S_RDMEM: begin
				cmd.rd_en = 1'b1;
				iter_d    = '0;
				state_d   = S_DIV;
			end
			S_DIV: begin
				cmd.div_en    = 1'b1;
				cmd.div_first = (iter_q == '0);
				iter_d        = iter_q + ITER_W'(1);
				if (iter_q == ITER_W'(DIV_ITERS - 1))
					state_d = S_ROUND;
			end
			S_ROUND: begin
				cmd.round_en = 1'b1;
				state_d      = S_DONE;
			end
			S_DONE: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
		cmd.status   = st_q;
		cmd.res_kind = res_q;
	end

endmodule
`default_nettype wire

// ===== hw/rtl/tacdf_datapath.sv =====
// Datapath of the triangle area CDF builder: edges, shared multiplier,
// square root, prefix memory, divider and result register. Uses tacdf_pkg.
`default_nettype none
module tacdf_datapath
	import tacdf_pkg::*;
#(
	parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
	parameter int COORD_BITS    = COORD_BITS_DEF,
	parameter int INDEX_W       = $clog2(MAX_TRIANGLES),
	parameter int COUNT_W       = $clog2(MAX_TRIANGLES + 1),
	parameter int IN_W          = ((9 * COORD_BITS + INDEX_W + 7) / 8) * 8,
	parameter int OUT_W         = ((CDF_W + COUNT_W + 7) / 8) * 8
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic [IN_W-1:0] s_tdata,
	input  wire logic [1:0]      s_tuser,
	input  wire tacdf_cmd_t      cmd,
	output tacdf_sts_t           sts,
	output logic [OUT_W-1:0]     m_tdata,
	output logic [STATUS_W-1:0]  m_tuser
);
	localparam int D     = COORD_BITS + 1;
	localparam int P_W   = 2 * D + 2;
	localparam int C_W   = 2 * D + 1;
	localparam int M_W   = 2 * D;
	localparam int SQ_W  = 4 * D;
	localparam int REM_W = 2 * D + 2;

	logic signed [COORD_BITS-1:0] crn [9];
	logic signed [D-1:0]          dif [6];
	action_t                      act_q;
	logic [INDEX_W-1:0]           idx_q;
	logic signed [D-1:0]          uv_q [6];
	logic signed [P_W-1:0]        prod_d;
	logic signed [P_W-1:0]        prod_q;
	logic signed [C_W-1:0]        c_q [3];
	logic [M_W-1:0]               mg [3];
	logic signed [D:0]            opa, opb;
	logic [SQ_W-1:0]              sq_q;
	logic [REM_W-1:0]             rem_q, rem_sh, trial;
	logic [M_W-1:0]               root_q;
	logic [SUM_W:0]               sum_raw;
	logic [SUM_W-1:0]             sum_sat;
	logic [SUM_W-1:0]             total_q;
	logic [COUNT_W-1:0]           count_q;
	logic [SUM_W-1:0]             mem [MAX_TRIANGLES];
	logic [SUM_W-1:0]             rd_q;
	logic [SUM_W-1:0]             r_q;
	logic [SUM_W:0]               den, t_div, t_sub;
	logic                         ge;
	logic [CDF_W-1:0]             q_q;
	logic [CDF_W:0]               q_inc;
	logic [CDF_W-1:0]             cdf_q;
	logic [COUNT_W-1:0]           cnt_q;
	logic [STATUS_W-1:0]          stat_q;

	// Edge vectors B-A and C-A straight off the input bus
	always_comb begin
		for (int k = 0; k < 9; k++)
			crn[k] = s_tdata[k*COORD_BITS +: COORD_BITS];
		for (int k = 0; k < 3; k++) begin
			dif[k]   = D'(crn[3+k]) - D'(crn[k]);
			dif[3+k] = D'(crn[6+k]) - D'(crn[k]);
		end
	end

	always_comb begin
		for (int k = 0; k < 3; k++)
			mg[k] = c_q[k][C_W-1] ? M_W'(-c_q[k]) : M_W'(c_q[k]);
	end

	function automatic logic signed [D:0] pick(input opnd_t s);
		logic signed [D:0] o;
		case (s)
			OP_UX:   o = (D+1)'(uv_q[0]);
			OP_UY:   o = (D+1)'(uv_q[1]);
			OP_UZ:   o = (D+1)'(uv_q[2]);
			OP_VX:   o = (D+1)'(uv_q[3]);
			OP_VY:   o = (D+1)'(uv_q[4]);
			OP_VZ:   o = (D+1)'(uv_q[5]);
			OP_H0:   o = {1'b0, mg[0][M_W-1:D]};
			OP_L0:   o = {1'b0, mg[0][D-1:0]};
			OP_H1:   o = {1'b0, mg[1][M_W-1:D]};
			OP_L1:   o = {1'b0, mg[1][D-1:0]};
			OP_H2:   o = {1'b0, mg[2][M_W-1:D]};
			OP_L2:   o = {1'b0, mg[2][D-1:0]};
			default: o = '0;
		endcase
		return o;
	endfunction

	assign opa = pick(cmd.mstep.a);
	assign opb = pick(cmd.mstep.b);

	// Full-width signed product of the two selected operands
	assign prod_d = opa * opb;

	// Square root: two radicand bits in, one root bit out per cycle
	assign rem_sh = {rem_q[REM_W-3:0], sq_q[SQ_W-1 -: 2]};
	assign trial  = {root_q, 2'b01};

	assign sum_raw = {1'b0, total_q} + (SUM_W+1)'(root_q);
	assign sum_sat = sum_raw[SUM_W] ? SUM_MAX : sum_raw[SUM_W-1:0];

	assign den   = {1'b0, total_q};
	assign t_div = cmd.div_first ? {1'b0, rd_q} : {r_q, 1'b0};
	assign ge    = (t_div >= den);
	assign t_sub = t_div - den;
	assign q_inc = {1'b0, q_q} + (CDF_W+1)'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			count_q <= '0;
		end else if (cmd.clear) begin
			total_q <= '0;
			count_q <= '0;
		end else if (cmd.append) begin
			total_q <= sum_sat;
			count_q <= count_q + COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q  <= action_t'(s_tuser);
			idx_q  <= s_tdata[9*COORD_BITS +: INDEX_W];
			for (int k = 0; k < 6; k++)
				uv_q[k] <= dif[k];
			sq_q   <= '0;
			rem_q  <= '0;
			root_q <= '0;
		end
		if (cmd.mul_en) begin
			prod_q <= prod_d;
			case (cmd.mstep.acc)
				ACC_LOAD:  c_q[cmd.mstep.tgt] <= C_W'(prod_q);
				ACC_SUB:   c_q[cmd.mstep.tgt] <= c_q[cmd.mstep.tgt] - C_W'(prod_q);
				ACC_SQHI:  sq_q <= sq_q + (SQ_W'(prod_q[M_W-1:0]) << (2 * D));
				ACC_SQMID: sq_q <= sq_q + (SQ_W'(prod_q[M_W-1:0]) << (D + 1));
				ACC_SQLO:  sq_q <= sq_q + SQ_W'(prod_q[M_W-1:0]);
				default: ;
			endcase
		end
		if (cmd.sqrt_en) begin
			sq_q <= sq_q << 2;
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[M_W-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[M_W-2:0], 1'b0};
			end
		end
		if (cmd.append)
			mem[count_q[INDEX_W-1:0]] <= sum_sat;
		if (cmd.rd_en)
			rd_q <= mem[idx_q];
		if (cmd.div_en) begin
			r_q <= ge ? t_sub[SUM_W-1:0] : t_div[SUM_W-1:0];
			q_q <= cmd.div_first ? CDF_W'(ge) : {q_q[CDF_W-2:0], ge};
		end
		if (cmd.round_en && ({r_q, 1'b0} >= den))
			q_q <= (q_inc > (CDF_W+1)'(CDF_ONE)) ? CDF_ONE : q_inc[CDF_W-1:0];
		if (cmd.out_load) begin
			case (cmd.res_kind)
				RES_ONE: cdf_q <= CDF_ONE;
				RES_DIV: cdf_q <= q_q;
				default: cdf_q <= '0;
			endcase
			cnt_q  <= count_q;
			stat_q <= cmd.status;
		end
	end

	assign sts.action     = act_q;
	assign sts.full       = (count_q >= COUNT_W'(MAX_TRIANGLES));
	assign sts.idx_out    = (COUNT_W'(idx_q) >= count_q);
	assign sts.idx_last   = ((COUNT_W'(idx_q) + COUNT_W'(1)) == count_q);
	assign sts.total_zero = (total_q == '0);

	assign m_tdata = OUT_W'({cnt_q, cdf_q});
	assign m_tuser = stat_q;

endmodule
`default_nettype wire

// ===== hw/rtl/tacdf_checker.sv =====
// Port-level checks for triangle_area_cdf_builder, bound to the top level.
// Uses tacdf_pkg for status codes and the Q1.16 one.
`default_nettype none
module tacdf_checker
	import tacdf_pkg::*;
#(
	parameter int MAX_TRIANGLES = MAX_TRIANGLES_DEF,
	parameter int COUNT_W       = $clog2(MAX_TRIANGLES + 1),
	parameter int OUT_W         = ((CDF_W + COUNT_W + 7) / 8) * 8
) (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [OUT_W-1:0]    m_tdata,
	input wire logic [STATUS_W-1:0] m_tuser
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tuser == STATUS_OK || m_tuser == STATUS_FULL ||
			m_tuser == STATUS_RANGE))
		else $error("bad status code");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != STATUS_OK |-> m_tdata[CDF_W-1:0] == '0)
		else $error("nonzero fraction on rejected item");

	a_full_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STATUS_FULL |->
			m_tdata[CDF_W +: COUNT_W] == COUNT_W'(MAX_TRIANGLES))
		else $error("table full reported below capacity");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[CDF_W-1:0] <= CDF_ONE)
		else $error("fraction above one");

endmodule

bind triangle_area_cdf_builder tacdf_checker #(
	.MAX_TRIANGLES (MAX_TRIANGLES),
	.COUNT_W       (COUNT_W),
	.OUT_W         (OUT_W)
) u_tacdf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);
`default_nettype wire
